// File: src/assert_macros.svh
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define AGL_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Check a property on every clock edge, reset included.
`define AGL_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// File: src/aglrf_pkg.sv
// Shared types, constants and the tanh table of the gain-limiting frame FIFO.
package aglrf_pkg;

  localparam int CAP_FRAMES   = 1024;
  localparam int MAX_CHANNELS = 8;
  localparam int TANH_ENTRIES = 256;

  localparam int FPTR_W = $clog2(CAP_FRAMES);
  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int ADDR_W = $clog2(CAP_FRAMES * MAX_CHANNELS);
  localparam int HELD_W = $clog2(CAP_FRAMES + 1);
  localparam int IDX_W  = $clog2(TANH_ENTRIES);

  // |x| < 4 in Q.15 spans 17 bits
  localparam int LIM_W = 17;

  localparam logic [15:0] GAIN_RESET     = 16'd4096;
  localparam logic [3:0]  CH_COUNT_RESET = 4'd2;
  localparam logic [15:0] MAG_MAX        = 16'd32767;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  typedef enum logic [1:0] {
    REG_STREAM_ON,
    REG_GAIN,
    REG_LIMITER_ON,
    REG_CHANNEL_COUNT
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_DATA,
    ST_UNDERRUN,
    ST_STOPPED
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCALE,
    S_LUT,
    S_INTERP,
    S_STORE,
    S_RD_ADDR,
    S_RD_DATA,
    S_RD_ZERO,
    S_RD_STOP
  } state_t;

  typedef struct packed {
    logic               action;
    logic signed [15:0] sample_in;
  } req_t;

  typedef struct packed {
    logic signed [15:0] sample_out;
    logic [2:0]         channel;
    logic               last;
    logic [1:0]         status;
    logic [10:0]        frames_held;
  } rsp_t;

  typedef logic [15:0] tanh_tab_t [0:TANH_ENTRIES];

  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

  // Shift-subtract quotient, evaluated at elaboration only.
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // e^(-z) for small z, Q30 in and out, alternating series.
  function automatic logic [63:0] exp_neg_small(input logic [63:0] z);
    logic [63:0] term;
    logic [63:0] sum;
    term = ONE_Q30;
    sum  = ONE_Q30;
    for (int k = 1; k <= 14; k++) begin
      term = udiv64((term * z) >> 30, 64'(k));
      if ((k % 2) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  // tanh(4k/N) in Q1.15, via (1 - e^-2x) / (1 + e^-2x)
  function automatic logic [15:0] tanh_point(input int k);
    logic [63:0] z;
    logic [63:0] d;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] r;
    z = (64'(k) << 29) / TANH_ENTRIES;
    d = exp_neg_small(z);
    for (int s = 0; s < 4; s++) begin
      d = (d * d + (64'd1 << 29)) >> 30;
    end
    if (d > ONE_Q30) begin
      d = ONE_Q30;
    end
    num = (ONE_Q30 - d) * 64'd65536;
    den = ONE_Q30 + d;
    r   = udiv64(num + den, den << 1);
    return (r > 64'(MAG_MAX)) ? MAG_MAX : 16'(r);
  endfunction

  function automatic tanh_tab_t build_tanh_tab();
    tanh_tab_t tab;
    for (int k = 0; k <= TANH_ENTRIES; k++) begin
      tab[k] = tanh_point(k);
    end
    return tab;
  endfunction

  localparam tanh_tab_t TANH_TAB = build_tanh_tab();

endpackage

// File: src/audio_gain_limit_ring_fifo_top.sv
// Gain, limiter and interleaved frame ring FIFO: top level.
//
//  channel | signals                      | carries
//  --------+------------------------------+-------------------------------------
//  request | req_valid, req_stall, req    | write one sample or read one frame
//  result  | rsp_valid, rsp_stall, rsp    | one sample per channel of a frame
//  config  | cfg_write, cfg_index, cfg_data | stream_on, gain, limiter_on, channels
//
//  A write runs S_SCALE then S_STORE with the limiter off, and S_SCALE,
//  S_LUT, S_INTERP, S_STORE with it on: the gain multiplier, the table
//  lookup and the interpolation multiplier each sit behind a register.
//  A write while stopped is dropped in its accept cycle. A read runs
//  S_RD_ADDR then S_RD_DATA for each channel, as the ring's read port is
//  registered. Results leave through one output register, so a stall holds
//  the sequencer only when that register is still full. Reset (rst,
//  synchronous) clears pointers, counts, config and output valid, not the ring.
module audio_gain_limit_ring_fifo_top import aglrf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp,
  input  logic        cfg_write,
  input  cfg_reg_t    cfg_index,
  input  logic [15:0] cfg_data
);

  // Configuration
  logic        stream_on;
  logic [15:0] gain;
  logic        limiter_on;
  logic [3:0]  channel_count;
  logic [3:0]  cc_eff;

  // Ring bookkeeping
  logic [FPTR_W-1:0] wptr;
  logic [CH_W-1:0]   wch;
  logic [FPTR_W-1:0] rptr;
  logic [HELD_W-1:0] held;

  state_t state;
  state_t state_next;

  // Write datapath registers
  logic signed [32:0] prod;
  logic signed [15:0] sat_val;
  logic               mag_neg;
  logic               lim_sat;
  logic               use_lim;
  logic [IDX_W-1:0]   lut_idx;
  logic [LIM_W-1:0]   frac;
  logic [15:0]        lut_lo;
  logic [15:0]        lut_diff;
  logic [32:0]        interp;

  // Read sequencer registers
  logic [FPTR_W-1:0] rd_frame;
  logic [CH_W-1:0]   rd_ch;
  logic [HELD_W-1:0] held_lat;
  logic              rd_last;

  // Ring memory
  logic [15:0]       ring [0:CAP_FRAMES*MAX_CHANNELS-1];
  logic [15:0]       mem_q;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [15:0]       wdata;
  logic              ring_we;

  // Output register
  logic out_valid;
  rsp_t out_data;
  rsp_t out_next;
  logic out_load;
  logic out_free;

  logic req_accept;

  // Combinational pieces of the write path
  logic signed [33:0] psum;
  logic signed [21:0] vq;
  logic signed [15:0] sat_c;
  logic [21:0]        a_abs;
  logic [LIM_W-1:0]   a_low;
  logic [33:0]        interp_rnd;
  logic [16:0]        mag_c;
  logic [15:0]        mag_cap;
  logic [15:0]        lim_val;
  logic [CH_W-1:0]    wch_c;
  logic               frame_done;

  assign req_accept = req_valid && !req_stall;
  assign out_free   = !out_valid || !rsp_stall;
  assign rsp_valid  = out_valid;
  assign rsp        = out_data;

  // Treat zero channels as one and clip at the frame width
  always_comb begin
    cc_eff = channel_count;
    if (channel_count == 4'd0) begin
      cc_eff = 4'd1;
    end else if (channel_count > 4'(MAX_CHANNELS)) begin
      cc_eff = 4'(MAX_CHANNELS);
    end
  end

  // Round the Q6.27 product to Q.15, then clamp or take the magnitude
  always_comb begin
    psum  = {prod[32], prod} + 34'sd2048;
    vq    = psum[33:12];
    sat_c = vq[15:0];
    if (vq > 22'sd32767) begin
      sat_c = 16'sh7fff;
    end else if (vq < -22'sd32768) begin
      sat_c = -16'sh8000;
    end
    a_abs = vq[21] ? 22'(-vq) : 22'(vq);
    a_low = a_abs[LIM_W-1:0];
  end

  // Interpolate between table points and restore the sign
  always_comb begin
    interp_rnd = {1'b0, interp} + 34'd65536;
    mag_c      = 17'(lut_lo) + 17'(interp_rnd >> LIM_W);
    mag_cap    = (lim_sat || mag_c > 17'(MAG_MAX)) ? MAG_MAX : mag_c[15:0];
    lim_val    = mag_neg ? 16'(-mag_cap) : mag_cap;
    wdata      = use_lim ? lim_val : sat_val;
  end

  // Hold the channel slot inside the frame; finish the frame on its last channel
  always_comb begin
    wch_c = wch;
    if (32'(wch) >= MAX_CHANNELS) begin
      wch_c = CH_W'(MAX_CHANNELS - 1);
    end
    frame_done = (4'(wch_c) + 4'd1) >= cc_eff;
  end

  assign wr_addr = ADDR_W'(ADDR_W'(wptr) * ADDR_W'(MAX_CHANNELS)) + ADDR_W'(wch_c);
  assign rd_addr = ADDR_W'(ADDR_W'(rd_frame) * ADDR_W'(MAX_CHANNELS)) + ADDR_W'(rd_ch);
  assign rd_last = (4'(rd_ch) + 4'd1) == cc_eff;

  // Next state and output loading
  always_comb begin
    state_next = state;
    req_stall  = (state != S_IDLE);
    out_load   = 1'b0;
    out_next   = out_data;
    ring_we    = 1'b0;
    case (state)
      S_IDLE: begin
        if (req_accept) begin
          if (req.action == ACT_READ) begin
            if (!stream_on) begin
              state_next = S_RD_STOP;
            end else if (held == '0) begin
              state_next = S_RD_ZERO;
            end else begin
              state_next = S_RD_ADDR;
            end
          end else if (stream_on) begin
            state_next = S_SCALE;
          end
        end
      end
      S_SCALE: begin
        state_next = limiter_on ? S_LUT : S_STORE;
      end
      S_LUT: begin
        state_next = S_INTERP;
      end
      S_INTERP: begin
        state_next = S_STORE;
      end
      S_STORE: begin
        ring_we    = 1'b1;
        state_next = S_IDLE;
      end
      S_RD_ADDR: begin
        state_next = S_RD_DATA;
      end
      S_RD_DATA: begin
        if (out_free) begin
          out_load             = 1'b1;
          out_next.sample_out  = mem_q;
          out_next.channel     = 3'(rd_ch);
          out_next.last        = rd_last;
          out_next.status      = ST_DATA;
          out_next.frames_held = 11'(held_lat);
          state_next           = rd_last ? S_IDLE : S_RD_ADDR;
        end
      end
      S_RD_ZERO: begin
        if (out_free) begin
          out_load             = 1'b1;
          out_next.sample_out  = '0;
          out_next.channel     = 3'(rd_ch);
          out_next.last        = rd_last;
          out_next.status      = ST_UNDERRUN;
          out_next.frames_held = '0;
          state_next           = rd_last ? S_IDLE : S_RD_ZERO;
        end
      end
      S_RD_STOP: begin
        if (out_free) begin
          out_load             = 1'b1;
          out_next.sample_out  = '0;
          out_next.channel     = '0;
          out_next.last        = 1'b1;
          out_next.status      = ST_STOPPED;
          out_next.frames_held = 11'(held);
          state_next           = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      stream_on     <= 1'b0;
      gain          <= GAIN_RESET;
      limiter_on    <= 1'b0;
      channel_count <= CH_COUNT_RESET;
      wptr          <= '0;
      wch           <= '0;
      rptr          <= '0;
      held          <= '0;
      rd_ch         <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_write) begin
        case (cfg_index)
          REG_STREAM_ON:     stream_on     <= cfg_data[0];
          REG_GAIN:          gain          <= cfg_data;
          REG_LIMITER_ON:    limiter_on    <= cfg_data[0];
          REG_CHANNEL_COUNT: channel_count <= cfg_data[3:0];
          default: ;
        endcase
      end

      // Take a frame off at accept; the sequencer reads from the latched slot
      if (state == S_IDLE && req_accept && req.action == ACT_READ) begin
        rd_ch <= '0;
        if (stream_on && held != '0) begin
          held <= held - HELD_W'(1);
          rptr <= (32'(rptr) == CAP_FRAMES - 1) ? '0 : rptr + FPTR_W'(1);
        end
      end

      if ((state == S_RD_DATA || state == S_RD_ZERO) && out_load) begin
        rd_ch <= rd_ch + CH_W'(1);
      end

      // Advance the write slot; count the frame, saturating at capacity
      if (state == S_STORE) begin
        if (frame_done) begin
          wch  <= '0;
          wptr <= (32'(wptr) == CAP_FRAMES - 1) ? '0 : wptr + FPTR_W'(1);
          if (32'(held) < CAP_FRAMES) begin
            held <= held + HELD_W'(1);
          end
        end else begin
          wch <= wch_c + CH_W'(1);
        end
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!rsp_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_accept) begin
      prod     <= 33'(req.sample_in) * 33'($signed({1'b0, gain}));
      rd_frame <= rptr;
      held_lat <= held - HELD_W'(1);
    end
    if (state == S_SCALE) begin
      sat_val <= sat_c;
      mag_neg <= vq[21];
      lim_sat <= a_abs >= 22'(1 << LIM_W);
      use_lim <= limiter_on;
      lut_idx <= IDX_W'(a_low >> (LIM_W - IDX_W));
      frac    <= LIM_W'(a_low << IDX_W);
    end
    if (state == S_LUT) begin
      lut_lo   <= TANH_TAB[lut_idx];
      lut_diff <= TANH_TAB[(IDX_W+1)'(lut_idx) + (IDX_W+1)'(1)] - TANH_TAB[lut_idx];
    end
    if (state == S_INTERP) begin
      interp <= 33'(lut_diff) * 33'(frac);
    end
    if (out_load) begin
      out_data <= out_next;
    end
  end

  // Ring: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[wr_addr] <= wdata;
    end
    mem_q <= ring[rd_addr];
  end

endmodule

// File: src/aglrf_checker.sv
// Port-level checker for the gain-limiting frame FIFO, bound to the top level.
`include "assert_macros.svh"

module aglrf_checker import aglrf_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_stall,
  input req_t        req,
  input logic        rsp_valid,
  input logic        rsp_stall,
  input rsp_t        rsp,
  input logic        cfg_write,
  input cfg_reg_t    cfg_index,
  input logic [15:0] cfg_data
);

  `AGL_ASSERT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp), "stalled result changed")
  `AGL_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !rsp_valid, "result valid straight after reset")
  `AGL_ASSERT(a_underrun_zero, clk, rst, rsp_valid && rsp.status == ST_UNDERRUN |-> rsp.sample_out == 16'sd0 && rsp.frames_held == 11'd0, "underrun result not zero")
  `AGL_ASSERT(a_stop_form, clk, rst, rsp_valid && rsp.status == ST_STOPPED |-> rsp.last && rsp.channel == 3'd0 && rsp.sample_out == 16'sd0, "stopped result malformed")
  `AGL_ASSERT(a_held_bound, clk, rst, rsp_valid |-> rsp.frames_held <= 11'(CAP_FRAMES), "frames held beyond capacity")

endmodule

bind audio_gain_limit_ring_fifo_top aglrf_checker u_aglrf_checker (.*);

// File: test/aglrf_frame_checker.sv
// Frame checker for the gain-limiting ring FIFO: predicts every read and compares its results.
module aglrf_frame_checker import aglrf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  input  logic     req_stall,
  input  req_t     req,
  input  logic     rsp_valid,
  input  logic     rsp_stall,
  input  rsp_t     rsp,
  input  logic     cfg_write,
  input  cfg_reg_t cfg_index,
  input  logic [15:0] cfg_data,
  output int       fail_count,
  output int       pending
);

  localparam longint unsigned Q30_ONE = 64'd1 << 30;
  localparam longint unsigned SPAN_4  = 64'd131072;

  logic [15:0]       tanh_lut [0:TANH_ENTRIES];
  logic [15:0]       ring_mem [0:CAP_FRAMES*MAX_CHANNELS-1];
  logic [FPTR_W-1:0] wr_frame;
  logic [FPTR_W-1:0] rd_frame;
  logic [CH_W-1:0]   wr_chan;
  logic [HELD_W-1:0] held;
  logic              stream_en;
  logic              limit_en;
  logic [15:0]       gain_q412;
  logic [3:0]        chan_cfg;
  rsp_t              expected_frames_q [$];

  // tanh(4k/N) in Q1.15 from a Q30 series for e^(-z), squared up four times
  function automatic logic [15:0] tanh_entry(input int k);
    longint unsigned z, d, term, sum, num, den, r;
    z    = (longint'(k) << 29) / TANH_ENTRIES;
    term = Q30_ONE;
    sum  = Q30_ONE;
    for (int n = 1; n <= 14; n++) begin
      term = ((term * z) >> 30) / n;
      if (n % 2) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    d = sum;
    repeat (4) d = (d * d + (64'd1 << 29)) >> 30;
    if (d > Q30_ONE) d = Q30_ONE;
    num = (Q30_ONE - d) * 64'd65536;
    den = Q30_ONE + d;
    r   = (num + den) / (2 * den);
    return (r > 64'd32767) ? 16'h7FFF : r[15:0];
  endfunction

  function automatic int frame_width();
    if (chan_cfg == 4'd0) return 1;
    if (chan_cfg > MAX_CHANNELS) return MAX_CHANNELS;
    return int'(chan_cfg);
  endfunction

  // gain, round to Q.15, then clamp or soft-limit
  function automatic logic [15:0] scaled_sample(input logic signed [15:0] s);
    longint p, v;
    longint unsigned a, an, idx, frac, mag, lo, hi;
    p = longint'(s) * longint'(gain_q412);
    v = (p + 2048) >>> 12;
    if (!limit_en) begin
      if (v > 32767) return 16'h7FFF;
      if (v < -32768) return 16'h8000;
      return v[15:0];
    end
    a = (v < 0) ? -v : v;
    if (a >= SPAN_4) begin
      mag = 64'd32767;
    end else begin
      an   = a * TANH_ENTRIES;
      idx  = an / SPAN_4;
      frac = an - idx * SPAN_4;
      lo   = tanh_lut[idx];
      hi   = tanh_lut[idx + 1];
      mag  = lo + ((hi - lo) * frac + 64'd65536) / SPAN_4;
      if (mag > 64'd32767) mag = 64'd32767;
    end
    return (v < 0) ? -16'(mag) : 16'(mag);
  endfunction

  task automatic log_mismatch(input bit has_exp, input rsp_t exp_r, input rsp_t got);
    fail_count++;
    if (fail_count <= 10) begin
      if (has_exp) begin
        $display("result mismatch: expected sample %0d ch %0d last %b status %0d held %0d, got sample %0d ch %0d last %b status %0d held %0d",
                 exp_r.sample_out, exp_r.channel, exp_r.last, exp_r.status,
                 exp_r.frames_held, got.sample_out, got.channel, got.last,
                 got.status, got.frames_held);
      end else begin
        $display("result with nothing expected: sample %0d ch %0d last %b status %0d held %0d",
                 got.sample_out, got.channel, got.last, got.status, got.frames_held);
      end
    end
  endtask

  initial begin
    for (int k = 0; k <= TANH_ENTRIES; k++) tanh_lut[k] = tanh_entry(k);
  end

  always @(posedge clk) begin
    int   width;
    rsp_t item;
    rsp_t want;
    if (rst) begin
      wr_frame   = '0;
      rd_frame   = '0;
      wr_chan    = '0;
      held       = '0;
      stream_en  = 1'b0;
      limit_en   = 1'b0;
      gain_q412  = GAIN_RESET;
      chan_cfg   = CH_COUNT_RESET;
      expected_frames_q.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_frames_q.size() == 0) begin
          log_mismatch(1'b0, '0, rsp);
        end else begin
          want = expected_frames_q.pop_front();
          if (rsp.sample_out !== want.sample_out || rsp.channel !== want.channel ||
              rsp.last !== want.last || rsp.status !== want.status ||
              rsp.frames_held !== want.frames_held) begin
            log_mismatch(1'b1, want, rsp);
          end
        end
      end

      if (cfg_write) begin
        case (cfg_index)
          REG_STREAM_ON:     stream_en = cfg_data[0];
          REG_GAIN:          gain_q412 = cfg_data;
          REG_LIMITER_ON:    limit_en  = cfg_data[0];
          REG_CHANNEL_COUNT: chan_cfg  = cfg_data[3:0];
          default: ;
        endcase
      end

      if (req_valid && !req_stall) begin
        width = frame_width();
        if (req.action == ACT_WRITE) begin
          if (stream_en) begin
            ring_mem[int'(wr_frame) * MAX_CHANNELS + int'(wr_chan)] = scaled_sample(req.sample_in);
            if (int'(wr_chan) + 1 >= width) begin
              wr_chan  = '0;
              wr_frame = wr_frame + 1'b1;
              if (held < CAP_FRAMES) held = held + 1'b1;
            end else begin
              wr_chan = wr_chan + 1'b1;
            end
          end
        end else if (!stream_en) begin
          item.sample_out  = '0;
          item.channel     = '0;
          item.last        = 1'b1;
          item.status      = ST_STOPPED;
          item.frames_held = held;
          expected_frames_q.push_back(item);
        end else if (held == 0) begin
          for (int c = 0; c < width; c++) begin
            item.sample_out  = '0;
            item.channel     = 3'(c);
            item.last        = (c + 1 == width);
            item.status      = ST_UNDERRUN;
            item.frames_held = '0;
            expected_frames_q.push_back(item);
          end
        end else begin
          held = held - 1'b1;
          for (int c = 0; c < width; c++) begin
            item.sample_out  = ring_mem[int'(rd_frame) * MAX_CHANNELS + c];
            item.channel     = 3'(c);
            item.last        = (c + 1 == width);
            item.status      = ST_DATA;
            item.frames_held = held;
            expected_frames_q.push_back(item);
          end
          rd_frame = rd_frame + 1'b1;
        end
      end
    end
    pending = expected_frames_q.size();
  end

endmodule

// File: test/audio_gain_limit_ring_fifo_top_tb.sv
// Testbench top for the gain-limiting ring FIFO: stimulus, idling and the verdict.
module audio_gain_limit_ring_fifo_top_tb;
  import aglrf_pkg::*;

  // Generous bound for the watchdog.
  localparam int CYCLE_LIMIT  = 1_000_000;
  // A write may still be in the gain/table/interpolation pipe after its accept.
  localparam int QUIET_CYCLES = 24;

  logic        clk;
  logic        rst       = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  req_t        req       = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  rsp_t        rsp;
  logic        cfg_write = 1'b0;
  cfg_reg_t    cfg_index = REG_STREAM_ON;
  logic [15:0] cfg_data  = '0;

  int fail_count;
  int pending;
  int cycles   = 0;
  int snd_idle = 0;
  int rcv_idle = 0;
  // Samples in the open frame and whole frames the block should hold.
  int fill     = 0;
  int frames   = 0;

  audio_gain_limit_ring_fifo_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  aglrf_frame_checker chk (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Receiver: stall at random on the falling edge, one decision per cycle.
  always @(negedge clk) begin
    rsp_stall <= ($urandom_range(0, 99) < rcv_idle);
  end

  // Watchdog: a hang or a lost result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("audio_gain_limit_ring_fifo_top verification failed");
      $finish;
    end
  end

  // Present one item from a falling edge and hold it until accepted. Valid is
  // left high afterwards: the next call either idles or replaces the payload
  // in the same step, so no edge ever sees a stale item.
  task automatic send_item(input logic act, input logic [15:0] smp);
    while ($urandom_range(0, 99) < snd_idle) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid     <= 1'b1;
    req.action    <= act;
    req.sample_in <= smp;
    do @(posedge clk); while (req_stall);
    @(negedge clk);
  endtask

  // Drop valid, wait for every expected result, then let the pipe run dry.
  task automatic settle();
    req_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  // Hold the write enable high across back-to-back writes; callers lower it.
  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  // Idle the block, then write all four registers. Unused upper data bits
  // carry noise, which the block must mask off.
  task automatic apply_cfg(input logic on, input logic [15:0] g, input logic lim,
                           input logic [3:0] chans);
    settle();
    write_reg(REG_STREAM_ON, {15'($urandom), on});
    write_reg(REG_GAIN, g);
    write_reg(REG_LIMITER_ON, {15'($urandom), lim});
    write_reg(REG_CHANNEL_COUNT, {12'($urandom), chans});
    cfg_write <= 1'b0;
  endtask

  // Follow the frame count so that reads only land on written slots.
  task automatic track_write(input logic on, input int width);
    if (on) begin
      if (fill + 1 >= width) begin
        fill = 0;
        frames++;
      end else begin
        fill++;
      end
    end
  endtask

  // Mostly full-range noise, with the rails and quiet signals mixed in.
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'($signed($urandom_range(0, 511)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 3))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return GAIN_RESET;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int          width;
    int          sent;
    int          pick;
    logic [3:0]  chans;
    logic        on;

    snd_idle = 37;
    rcv_idle = 81;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Stream stopped out of reset: the read is refused, the write dropped.
    send_item(ACT_READ, 16'h0000);
    send_item(ACT_WRITE, 16'h1234);
    settle();

    // Reset gain, limiter and channel count: only streaming is switched on.
    write_reg(REG_STREAM_ON, 16'h0001);
    cfg_write <= 1'b0;
    send_item(ACT_WRITE, 16'h4000);
    send_item(ACT_WRITE, 16'hC000);
    send_item(ACT_READ, 16'h0000);

    // Hard clip at full gain on both rails, then an underrun.
    apply_cfg(1'b1, 16'hFFFF, 1'b0, 4'd2);
    send_item(ACT_WRITE, 16'h7FFF);
    send_item(ACT_WRITE, 16'h8000);
    send_item(ACT_READ, 16'h0000);
    send_item(ACT_READ, 16'h0000);

    // Limiter beyond |x| >= 4: magnitude pinned at full scale.
    apply_cfg(1'b1, 16'hFFFF, 1'b1, 4'd2);
    send_item(ACT_WRITE, 16'h7FFF);
    send_item(ACT_WRITE, 16'h8000);
    send_item(ACT_READ, 16'h0000);

    // Channel count above the maximum is held at eight; limiter on the table.
    apply_cfg(1'b1, GAIN_RESET, 1'b1, 4'd15);
    send_item(ACT_WRITE, 16'h7FFF);
    send_item(ACT_WRITE, 16'h8000);
    send_item(ACT_WRITE, 16'h0001);
    send_item(ACT_WRITE, 16'hFFFF);
    send_item(ACT_WRITE, 16'h4000);
    send_item(ACT_WRITE, 16'hC000);
    send_item(ACT_WRITE, 16'h1000);
    send_item(ACT_WRITE, 16'h0000);
    send_item(ACT_READ, 16'h0000);

    // Channel count of zero behaves as one.
    apply_cfg(1'b1, 16'h1800, 1'b1, 4'd0);
    send_item(ACT_WRITE, 16'h2000);
    send_item(ACT_READ, 16'h0000);

    // Shrink the frame mid-way: the next sample lands past the new last
    // channel and completes the frame.
    apply_cfg(1'b1, GAIN_RESET, 1'b0, 4'd4);
    send_item(ACT_WRITE, 16'h0100);
    send_item(ACT_WRITE, 16'hFF00);
    send_item(ACT_WRITE, 16'h0200);
    apply_cfg(1'b1, GAIN_RESET, 1'b0, 4'd2);
    send_item(ACT_WRITE, 16'hFE00);
    send_item(ACT_READ, 16'h0000);

    // Stop with a frame held: refused read reports it, the write vanishes.
    send_item(ACT_WRITE, 16'h0300);
    send_item(ACT_WRITE, 16'hFD00);
    apply_cfg(1'b0, GAIN_RESET, 1'b0, 4'd2);
    send_item(ACT_READ, 16'h0000);
    send_item(ACT_WRITE, 16'h7777);
    apply_cfg(1'b1, GAIN_RESET, 1'b0, 4'd2);
    send_item(ACT_READ, 16'h0000);
    send_item(ACT_READ, 16'h0000);

    // Random part: receiver-heavy idling, then sender-heavy, then none.
    // Every frame held is read out before the frame width may grow, so no
    // read reaches a channel slot that was never written.
    fill   = 0;
    frames = 0;
    for (int prof = 0; prof < 3; prof++) begin
      case (prof)
        0:       begin snd_idle = 37; rcv_idle = 81; end
        1:       begin snd_idle = 81; rcv_idle = 37; end
        default: begin snd_idle = 0;  rcv_idle = 0;  end
      endcase
      for (int set = 0; set < 4; set++) begin
        on    = ($urandom_range(0, 7) != 0);
        chans = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
        apply_cfg(on, pick_gain(), 1'($urandom), chans);
        width = (chans == 4'd0) ? 1 : ((chans > MAX_CHANNELS) ? MAX_CHANNELS : int'(chans));
        sent  = 0;
        // Mostly whole frames followed by reads; now and then a stray sample
        // that leaves a frame broken across the next burst.
        while (sent < 22) begin
          pick = $urandom_range(0, 9);
          if (pick < 5) begin
            for (int k = 0; k < width; k++) begin
              send_item(ACT_WRITE, pick_sample());
              track_write(on, width);
            end
            sent += width;
          end else if (pick < 9) begin
            send_item(ACT_READ, pick_sample());
            if (on && frames > 0) frames--;
            sent++;
          end else begin
            send_item(ACT_WRITE, pick_sample());
            track_write(on, width);
            sent++;
          end
        end
        // Drain the held frames at this width.
        while (on && frames > 0) begin
          send_item(ACT_READ, 16'h0000);
          frames--;
        end
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("audio_gain_limit_ring_fifo_top verification clean");
    end else begin
      $display("audio_gain_limit_ring_fifo_top verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/aglrf_pkg.sv
src/audio_gain_limit_ring_fifo_top.sv
src/aglrf_checker.sv
test/aglrf_frame_checker.sv
test/audio_gain_limit_ring_fifo_top_tb.sv
